/* hw/rtl/escape_sequence_byte_decoder_unit_assert.svh */
// Assertion macros for the escape decoder RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ESCAPE_SEQUENCE_BYTE_DECODER_UNIT_ASSERT_SVH
`define ESCAPE_SEQUENCE_BYTE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ESBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ESBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/esbd_pkg.sv */
// Types and constants of the escape sequence byte decoder.
// Depends on nothing; used by every module of the decoder.
package esbd_pkg;

    // Characters that drive the escape decoding.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_TAB  = 8'h09;
    localparam logic [7:0] BYTE_CR   = 8'h0D;

    // Offsets from a hex digit's character code to its value.
    localparam logic [7:0] OFS_DIGIT = 8'd48;
    localparam logic [7:0] OFS_UPPER = 8'd55;
    localparam logic [7:0] OFS_LOWER = 8'd87;

    // Decoder mode, one-hot.
    typedef enum logic [2:0] {
        MODE_TEXT = 3'b001,
        MODE_ESC  = 3'b010,
        MODE_HEX  = 3'b100
    } t_mode;

    // Input word.
    typedef struct packed {
        logic [7:0] in_char;
        logic       string_last;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       string_end;
    } t_out_word;

    // Work for the back end: one or two results caused by one input word.
    typedef struct packed {
        logic      two;
        t_out_word first;
        t_out_word second;
    } t_plan;

endpackage

/* hw/rtl/esbd_front.sv */
// Front end of the escape decoder: accepts input words, tracks escapes and
// plans each word with a result or string end. Depends on esbd_pkg.
module esbd_front import esbd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_word i_in_word,
    input  logic     i_plan_full,
    output logic     o_plan_push,
    output t_plan    o_plan
);

    t_mode      r_mode, n_mode;
    logic       r_wait, n_wait;
    logic [3:0] r_held, n_held;

    logic       accept;
    logic [7:0] c;
    logic       last;
    logic       is_hex;
    logic [7:0] hex_full;
    logic [3:0] dval;
    logic       a_has, b_has, t_has, a_valid;
    logic [7:0] a_byte, b_byte, t_byte;

    assign accept = i_push && !i_plan_full;
    assign c      = i_in_word.in_char;
    assign last   = i_in_word.string_last;

    // Hex digit detection and value.
    always_comb begin
        is_hex   = 1'b1;
        hex_full = c - OFS_DIGIT;
        if (c >= "0" && c <= "9") begin
            hex_full = c - OFS_DIGIT;
        end else if (c >= "A" && c <= "F") begin
            hex_full = c - OFS_UPPER;
        end else if (c >= "a" && c <= "f") begin
            hex_full = c - OFS_LOWER;
        end else begin
            is_hex = 1'b0;
        end
        dval = hex_full[3:0];
    end

    // Decode one word: up to two bytes and the next escape state.
    always_comb begin
        n_mode = r_mode;
        n_wait = r_wait;
        n_held = r_held;
        a_has  = 1'b0;
        a_byte = 8'h00;
        b_has  = 1'b0;
        b_byte = 8'h00;
        t_has  = 1'b0;
        t_byte = c;
        case (r_mode)
            MODE_ESC: begin
                n_mode = MODE_TEXT;
                a_has  = 1'b1;
                if (c == CH_N) begin
                    a_byte = BYTE_LF;
                end else if (c == CH_T) begin
                    a_byte = BYTE_TAB;
                end else if (c == CH_R) begin
                    a_byte = BYTE_CR;
                end else if (c == CH_X) begin
                    a_has  = 1'b0;
                    n_mode = MODE_HEX;
                    n_wait = 1'b0;
                    n_held = 4'h0;
                end else begin
                    a_byte = c;
                end
            end
            MODE_HEX: begin
                if (is_hex) begin
                    if (r_wait) begin
                        a_has  = 1'b1;
                        a_byte = {r_held, dval};
                        n_wait = 1'b0;
                        n_held = 4'h0;
                    end else begin
                        n_wait = 1'b1;
                        n_held = dval;
                        a_has  = last;
                        a_byte = {4'h0, dval};
                    end
                end else begin
                    // The run closes; the closing character is plain text unless it starts an escape.
                    a_has  = r_wait;
                    a_byte = {4'h0, r_held};
                    n_wait = 1'b0;
                    n_held = 4'h0;
                    if (c == CH_BSLASH && !last) begin
                        n_mode = MODE_ESC;
                    end else begin
                        n_mode = MODE_TEXT;
                        t_has  = 1'b1;
                    end
                end
            end
            default: begin
                if (c == CH_BSLASH && !last) begin
                    n_mode = MODE_ESC;
                end else begin
                    n_mode = MODE_TEXT;
                    a_has  = 1'b1;
                    a_byte = c;
                end
            end
        endcase
        // A plain-text byte goes after any byte the run left behind.
        if (t_has) begin
            if (a_has) begin
                b_has  = 1'b1;
                b_byte = t_byte;
            end else begin
                a_has  = 1'b1;
                a_byte = t_byte;
            end
        end
    end

    // Pack the plan; a string end with no byte gets an empty marker.
    assign a_valid = a_has || last;

    always_comb begin
        o_plan.two                = b_has;
        o_plan.first.out_byte     = a_has ? a_byte : 8'h00;
        o_plan.first.has_byte     = a_has;
        o_plan.first.run_last     = !b_has;
        o_plan.first.string_end   = last && !b_has;
        o_plan.second.out_byte    = b_byte;
        o_plan.second.has_byte    = 1'b1;
        o_plan.second.run_last    = 1'b1;
        o_plan.second.string_end  = last;
    end

    assign o_plan_push = accept && a_valid;

    // Escape state; the end of a string returns it to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TEXT;
            r_wait <= 1'b0;
            r_held <= 4'h0;
        end else if (accept) begin
            if (last) begin
                r_mode <= MODE_TEXT;
                r_wait <= 1'b0;
                r_held <= 4'h0;
            end else begin
                r_mode <= n_mode;
                r_wait <= n_wait;
                r_held <= n_held;
            end
        end
    end

endmodule

/* hw/rtl/esbd_fifo.sv */
// Plan queue between the front and back ends of the escape decoder.
// Depends on esbd_pkg.
module esbd_fifo import esbd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_plan i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_plan o_data,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_plan            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/esbd_back.sv */
// Back end of the escape decoder: expands plans into result words and
// holds them in the output register. Depends on esbd_pkg and the macros.
`include "escape_sequence_byte_decoder_unit_assert.svh"
module esbd_back import esbd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_plan     i_head,
    input  logic      i_head_valid,
    output logic      o_head_pop,
    input  logic      i_pop,
    output t_out_word o_out_word,
    output logic      o_empty
);

    t_out_word r_out, n_out;
    t_out_word r_sec, n_sec;
    logic      r_out_valid, n_out_valid;
    logic      r_sec_valid, n_sec_valid;
    logic      load;

    assign load = !r_out_valid || i_pop;

    // Refill the output register from the held second word or a new plan.
    always_comb begin
        n_out       = r_out;
        n_sec       = r_sec;
        n_out_valid = r_out_valid && !i_pop;
        n_sec_valid = r_sec_valid;
        o_head_pop  = 1'b0;
        if (load) begin
            if (r_sec_valid) begin
                n_out       = r_sec;
                n_out_valid = 1'b1;
                n_sec_valid = 1'b0;
            end else if (i_head_valid) begin
                n_out       = i_head.first;
                n_out_valid = 1'b1;
                o_head_pop  = 1'b1;
                if (i_head.two) begin
                    n_sec       = i_head.second;
                    n_sec_valid = 1'b1;
                end
            end
        end
    end

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sec_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_sec_valid <= n_sec_valid;
        end
    end

    // Result words.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_sec <= n_sec;
    end

    assign o_out_word = r_out;
    assign o_empty    = !r_out_valid;

    // A held second word always has its first word ahead of it.
    `ESBD_ASSERT_IMP(a_sec_behind_out, i_clk, i_rst_n, r_sec_valid, r_out_valid,
        "second word held with no word in the output register")
    // The string-end word is always the last word of its input.
    `ESBD_ASSERT_IMP(a_end_is_run_last, i_clk, i_rst_n, r_out_valid && r_out.string_end,
        r_out.run_last, "string end on a word that is not last of its input")
    // A word that is not last of its input is followed at once by its partner.
    `ESBD_ASSERT_NXT(a_partner_follows, i_clk, i_rst_n,
        r_out_valid && i_pop && !r_out.run_last, r_out_valid,
        "second word of an input did not follow the first")

endmodule

/* hw/rtl/escape_sequence_byte_decoder_unit.sv */
// Path: an accepted word is queued as a plan, then loaded into the output register.
// Throughput: one input word per cycle while the queue is not full and each word
// gives at most one result; a word's two results leave the single port in turn.
// The plan queue (DEPTH entries) lets input and output stall independently.
// Reset: synchronous, active low; clears the escape state, queue and output.
module escape_sequence_byte_decoder_unit import esbd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_word  i_in_word,
    output logic      full,
    input  logic      pop,
    output t_out_word o_out_word,
    output logic      empty
);

    logic  plan_push, plan_full, plan_pop, plan_empty;
    t_plan plan_in, plan_head;

    // Front end: classify words and build plans.
    esbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in_word   (i_in_word),
        .i_plan_full (plan_full),
        .o_plan_push (plan_push),
        .o_plan      (plan_in)
    );

    // Queue of plans between the two ends.
    esbd_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (plan_push),
        .i_data  (plan_in),
        .o_full  (plan_full),
        .i_pop   (plan_pop),
        .o_data  (plan_head),
        .o_empty (plan_empty)
    );

    // Back end: emit result words.
    esbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (plan_head),
        .i_head_valid (!plan_empty),
        .o_head_pop   (plan_pop),
        .i_pop        (pop),
        .o_out_word   (o_out_word),
        .o_empty      (empty)
    );

    assign full = plan_full;

endmodule
